/* rtl/core/upt_pkg.sv */
// ----------------------------------------------------------------------------
// upt_pkg: shared definitions for the up-counting PWM timer
// Field widths, register map, bus commands and output compare modes.
// ----------------------------------------------------------------------------
package upt_pkg;

   localparam int CMD_WIDTH      = 2;
   localparam int ADDR_WIDTH     = 4;
   localparam int DATA_WIDTH     = 16;
   localparam int MAX_CHANNELS   = 4;
   localparam int FLAG_WIDTH     = MAX_CHANNELS + 1;
   localparam int MODE_WIDTH     = 8;

   localparam int DEF_COUNTER_WIDTH = 16;
   localparam int DEF_NUM_CHANNELS  = 4;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   localparam logic [ADDR_WIDTH-1:0] ADDR_CTRL     = 4'd0;
   localparam logic [ADDR_WIDTH-1:0] ADDR_IRQ_EN   = 4'd1;
   localparam logic [ADDR_WIDTH-1:0] ADDR_STATUS   = 4'd2;
   localparam logic [ADDR_WIDTH-1:0] ADDR_EVENT    = 4'd3;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MODE_LO  = 4'd4;
   localparam logic [ADDR_WIDTH-1:0] ADDR_MODE_HI  = 4'd5;
   localparam logic [ADDR_WIDTH-1:0] ADDR_CHAN_EN  = 4'd6;
   localparam logic [ADDR_WIDTH-1:0] ADDR_COUNT    = 4'd7;
   localparam logic [ADDR_WIDTH-1:0] ADDR_PRESC    = 4'd8;
   localparam logic [ADDR_WIDTH-1:0] ADDR_RELOAD   = 4'd9;
   localparam logic [ADDR_WIDTH-1:0] ADDR_COMPARE0 = 4'd10;

   localparam int UPDATE_FLAG = 0;

   typedef enum logic [2:0] {
      OC_FROZEN     = 3'd0,
      OC_ACTIVE     = 3'd1,
      OC_INACTIVE   = 3'd2,
      OC_TOGGLE     = 3'd3,
      OC_FORCE_LOW  = 3'd4,
      OC_FORCE_HIGH = 3'd5,
      OC_PWM1       = 3'd6,
      OC_PWM2       = 3'd7
   } oc_mode_type;

endpackage

/* rtl/core/upt_req_if.sv */
// ----------------------------------------------------------------------------
// upt_req_if: bus request channel
// Valid/ready channel carrying one tick, register write or register read.
// ----------------------------------------------------------------------------
interface upt_req_if;
   logic                             valid;
   logic                             ready;
   logic [upt_pkg::CMD_WIDTH-1:0]    command;
   logic [upt_pkg::ADDR_WIDTH-1:0]   reg_address;
   logic [upt_pkg::DATA_WIDTH-1:0]   write_data;

   modport source (output valid, output command, output reg_address,
                   output write_data, input ready);
   modport sink   (input valid, input command, input reg_address,
                   input write_data, output ready);
endinterface

/* rtl/core/upt_rsp_if.sv */
// ----------------------------------------------------------------------------
// upt_rsp_if: response channel
// Valid/ready channel carrying read data, interrupt and channel outputs.
// ----------------------------------------------------------------------------
interface upt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [upt_pkg::DATA_WIDTH-1:0]      read_data;
   logic                                irq;
   logic [upt_pkg::MAX_CHANNELS-1:0]    channel_out;

   modport source (output valid, output read_data, output irq,
                   output channel_out, input ready);
   modport sink   (input valid, input read_data, input irq,
                   input channel_out, output ready);
endinterface

/* rtl/core/up_counting_pwm_timer.sv */
// ----------------------------------------------------------------------------
// up_counting_pwm_timer: up-counting timer with prescaler and compare channels
//
// Every beat on req_chan is a timer tick, a register write or a register read;
// every beat yields exactly one beat on rsp_chan with read data (zero unless a
// read), the interrupt line and the gated channel output levels after it.
// A request beat lands in an input register; once the output register is free
// or being taken, the timer state is updated and the response is stored in an
// output register. While the receiver does not stall, one beat is taken every
// cycle: the input register refills while the output register is taken.
// Throughput is set by the single state update stage, one beat per clock
// unless the receiver stalls. On a stall the response holds, the input
// register keeps one more beat and req_chan.ready drops until the output
// register drains. Synchronous reset clears both valid bits and all timer
// state; the reload register resets to all ones, everything else to zero.
// ----------------------------------------------------------------------------
module up_counting_pwm_timer #(
   parameter int COUNTER_WIDTH = upt_pkg::DEF_COUNTER_WIDTH,
   parameter int NUM_CHANNELS  = upt_pkg::DEF_NUM_CHANNELS
) (
   input  logic       clock,
   input  logic       reset,
   upt_req_if.sink    req_chan,
   upt_rsp_if.source  rsp_chan
);
   import upt_pkg::*;

   localparam int CW = COUNTER_WIDTH;
   localparam logic [FLAG_WIDTH-1:0] CHAN_FLAGS =
      FLAG_WIDTH'(((1 << NUM_CHANNELS) - 1) << 1);
   localparam logic [FLAG_WIDTH-1:0] FLAG_MASK = CHAN_FLAGS | FLAG_WIDTH'(1);

   // input register
   logic                  in_vld_ff;
   logic [CMD_WIDTH-1:0]  cmd_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [DATA_WIDTH-1:0] data_ff;

   // output register
   logic                    rsp_vld_ff;
   logic [DATA_WIDTH-1:0]   rd_ff, rd_in;
   logic                    irq_ff, irq_in;
   logic [MAX_CHANNELS-1:0] chout_ff, chout_in;

   // timer state
   logic                    count_en_ff, count_en_in;
   logic [FLAG_WIDTH-1:0]   irq_en_ff, irq_en_in;
   logic [FLAG_WIDTH-1:0]   flags_ff, flags_in;
   logic [MODE_WIDTH-1:0]   mode_ff [NUM_CHANNELS];
   logic [MODE_WIDTH-1:0]   mode_in [NUM_CHANNELS];
   logic [DATA_WIDTH-1:0]   chan_en_ff, chan_en_in;
   logic [CW-1:0]           counter_ff, counter_in;
   logic [DATA_WIDTH-1:0]   presc_pre_ff, presc_pre_in;
   logic [DATA_WIDTH-1:0]   presc_act_ff, presc_act_in;
   logic [DATA_WIDTH-1:0]   presc_cnt_ff, presc_cnt_in;
   logic [CW-1:0]           reload_ff, reload_in;
   logic [CW-1:0]           cmp_ff [NUM_CHANNELS];
   logic [CW-1:0]           cmp_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] levels_ff, levels_in;

   logic fire;
   logic [CW-1:0] wdata_cw;

   assign fire           = in_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || fire;
   assign wdata_cw       = CW'(data_ff);

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.read_data   = rd_ff;
   assign rsp_chan.irq         = irq_ff;
   assign rsp_chan.channel_out = chout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         cmd_ff  <= req_chan.command;
         addr_ff <= req_chan.reg_address;
         data_ff <= req_chan.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (fire) begin
         rd_ff    <= rd_in;
         irq_ff   <= irq_in;
         chout_ff <= chout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_en_ff  <= 1'b0;
         irq_en_ff    <= '0;
         flags_ff     <= '0;
         chan_en_ff   <= '0;
         counter_ff   <= '0;
         presc_pre_ff <= '0;
         presc_act_ff <= '0;
         presc_cnt_ff <= '0;
         reload_ff    <= '1;
         levels_ff    <= '0;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            mode_ff[ch] <= '0;
            cmp_ff[ch]  <= '0;
         end
      end else if (fire) begin
         count_en_ff  <= count_en_in;
         irq_en_ff    <= irq_en_in;
         flags_ff     <= flags_in;
         chan_en_ff   <= chan_en_in;
         counter_ff   <= counter_in;
         presc_pre_ff <= presc_pre_in;
         presc_act_ff <= presc_act_in;
         presc_cnt_ff <= presc_cnt_in;
         reload_ff    <= reload_in;
         levels_ff    <= levels_in;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            mode_ff[ch] <= mode_in[ch];
            cmp_ff[ch]  <= cmp_in[ch];
         end
      end
   end

   always_comb begin
      oc_mode_type mode;
      count_en_in  = count_en_ff;
      irq_en_in    = irq_en_ff;
      flags_in     = flags_ff;
      chan_en_in   = chan_en_ff;
      counter_in   = counter_ff;
      presc_pre_in = presc_pre_ff;
      presc_act_in = presc_act_ff;
      presc_cnt_in = presc_cnt_ff;
      reload_in    = reload_ff;
      levels_in    = levels_ff;
      mode_in      = mode_ff;
      cmp_in       = cmp_ff;
      rd_in        = '0;
      chout_in     = '0;

      case (cmd_type'(cmd_ff))
         CMD_TICK: begin
            if (count_en_ff) begin
               if (presc_cnt_ff != presc_act_ff) begin
                  presc_cnt_in = presc_cnt_ff + DATA_WIDTH'(1);
               end else begin
                  presc_cnt_in = '0;
                  if (counter_ff == reload_ff) begin
                     counter_in             = '0;
                     presc_act_in           = presc_pre_ff;
                     flags_in[UPDATE_FLAG]  = 1'b1;
                  end else begin
                     counter_in = counter_ff + CW'(1);
                  end
                  for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                     if (counter_in == cmp_ff[ch]) begin
                        flags_in[ch+1] = 1'b1;
                        mode = oc_mode_type'(mode_ff[ch][6:4]);
                        case (mode)
                           OC_ACTIVE:   levels_in[ch] = 1'b1;
                           OC_INACTIVE: levels_in[ch] = 1'b0;
                           OC_TOGGLE:   levels_in[ch] = ~levels_ff[ch];
                           default:     ;
                        endcase
                     end
                  end
               end
            end
         end
         CMD_WRITE: begin
            unique case (addr_ff)
               ADDR_CTRL:    count_en_in = data_ff[0];
               ADDR_IRQ_EN:  irq_en_in   = data_ff[FLAG_WIDTH-1:0];
               ADDR_STATUS:  flags_in    = flags_ff & data_ff[FLAG_WIDTH-1:0] & FLAG_MASK;
               ADDR_EVENT: begin
                  if (data_ff[0]) begin
                     counter_in            = '0;
                     presc_cnt_in          = '0;
                     presc_act_in          = presc_pre_ff;
                     flags_in[UPDATE_FLAG] = 1'b1;
                  end
                  flags_in = flags_in | (data_ff[FLAG_WIDTH-1:0] & CHAN_FLAGS);
               end
               ADDR_CHAN_EN: chan_en_in   = data_ff;
               ADDR_COUNT:   counter_in   = wdata_cw;
               ADDR_PRESC:   presc_pre_in = data_ff;
               ADDR_RELOAD:  reload_in    = wdata_cw;
               default: begin
                  for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                     if (addr_ff == ADDR_WIDTH'(ADDR_MODE_LO + (ch >> 1))) begin
                        mode_in[ch] = ((ch & 1) != 0) ? data_ff[15:8] : data_ff[7:0];
                     end
                     if (addr_ff == ADDR_WIDTH'(ADDR_COMPARE0 + ch)) begin
                        cmp_in[ch] = wdata_cw;
                     end
                  end
               end
            endcase
         end
         CMD_READ: begin
            unique case (addr_ff)
               ADDR_CTRL:    rd_in = DATA_WIDTH'(count_en_ff);
               ADDR_IRQ_EN:  rd_in = DATA_WIDTH'(irq_en_ff);
               ADDR_STATUS:  rd_in = DATA_WIDTH'(flags_ff);
               ADDR_CHAN_EN: rd_in = chan_en_ff;
               ADDR_COUNT:   rd_in = DATA_WIDTH'(counter_ff);
               ADDR_PRESC:   rd_in = presc_pre_ff;
               ADDR_RELOAD:  rd_in = DATA_WIDTH'(reload_ff);
               default: begin
                  for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                     if (addr_ff == ADDR_WIDTH'(ADDR_MODE_LO + (ch >> 1))) begin
                        if ((ch & 1) != 0) begin
                           rd_in[15:8] = mode_ff[ch];
                        end else begin
                           rd_in[7:0] = mode_ff[ch];
                        end
                     end
                     if (addr_ff == ADDR_WIDTH'(ADDR_COMPARE0 + ch)) begin
                        rd_in = DATA_WIDTH'(cmp_ff[ch]);
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase

      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         mode = oc_mode_type'(mode_in[ch][6:4]);
         case (mode)
            OC_FORCE_LOW:  levels_in[ch] = 1'b0;
            OC_FORCE_HIGH: levels_in[ch] = 1'b1;
            OC_PWM1:       levels_in[ch] = counter_in < cmp_in[ch];
            OC_PWM2:       levels_in[ch] = !(counter_in < cmp_in[ch]);
            default:       ;
         endcase
         chout_in[ch] = levels_in[ch] & chan_en_in[4*ch];
      end

      irq_in = |(flags_in & irq_en_in);
   end

`ifndef SYNTH
   a_absent_flags_clear: assert property (@(posedge clock) disable iff (reset)
      (flags_ff & ~FLAG_MASK) == '0)
      else $error("flag of absent channel set");

   a_beat_yields_response: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_vld_ff)
      else $error("request beat lost without response");

   a_stopped_counter_holds: assert property (@(posedge clock) disable iff (reset)
      fire && cmd_ff == CMD_TICK && !count_en_ff |=> $stable(counter_ff))
      else $error("counter moved while counting disabled");

   a_irq_matches_flags: assert property (@(posedge clock) disable iff (reset)
      fire |=> irq_ff == |(flags_ff & irq_en_ff))
      else $error("irq does not match enabled flags");
`endif

endmodule
